/* hw/rtl/bfps_pkg.sv */
package bfps_pkg;

   localparam int unsigned DEF_CAPACITY_BITS = 32768;
   localparam int unsigned MAX_FIELD = 64;

   localparam int unsigned FUNC_W = 2;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned WIDTH_W = 7;
   localparam int unsigned POS_W = 15;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned OFF_W = 6;

   typedef enum logic [FUNC_W-1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // Per-item control carried from the accept cycle to the write-back cycle.
   typedef struct packed {
      logic [FUNC_W-1:0]  op;
      logic               oor;
      logic [OFF_W-1:0]   off;
      logic [WIDTH_W-1:0] width;
   } ctl_type;

   // Mask of the low w bits, for w from 0 to 64.
   function automatic logic [VALUE_W-1:0] low_mask(input logic [WIDTH_W-1:0] w);
      logic [VALUE_W-1:0] m;
      if (w[WIDTH_W-1]) begin
         m = '1;
      end else begin
         m = ~({VALUE_W{1'b1}} << w[OFF_W-1:0]);
      end
      return m;
   endfunction

endpackage

/* hw/rtl/bfps_req_if.sv */
interface bfps_req_if;
   logic                              valid;
   logic                              ready;
   logic [bfps_pkg::FUNC_W-1:0]       func;
   logic [bfps_pkg::VALUE_W-1:0]      write_value;
   logic [bfps_pkg::WIDTH_W-1:0]      field_width;
   logic [bfps_pkg::POS_W-1:0]        bit_position;

   modport source (output valid, output func, output write_value, output field_width,
                   output bit_position, input ready);
   modport sink (input valid, input func, input write_value, input field_width,
                 input bit_position, output ready);
endinterface

/* hw/rtl/bfps_rsp_if.sv */
interface bfps_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bfps_pkg::VALUE_W-1:0]      read_value;
   logic [bfps_pkg::COUNT_W-1:0]      bit_count;
   logic                              out_of_range;

   modport source (output valid, output read_value, output bit_count, output out_of_range,
                   input ready);
   modport sink (input valid, input read_value, input bit_count, input out_of_range,
                 output ready);
endinterface

/* hw/rtl/bfps_merge.sv */
module bfps_merge (
   input  bfps_pkg::ctl_type              ctl,
   input  logic [bfps_pkg::VALUE_W-1:0]   lo_word,
   input  logic [bfps_pkg::VALUE_W-1:0]   hi_word,
   input  logic [2*bfps_pkg::VALUE_W-1:0] wdata,
   input  logic [2*bfps_pkg::VALUE_W-1:0] wmask,
   output logic [bfps_pkg::VALUE_W-1:0]   merged_lo,
   output logic [bfps_pkg::VALUE_W-1:0]   merged_hi,
   output logic [bfps_pkg::VALUE_W-1:0]   read_value
);
   import bfps_pkg::*;

   logic [2*VALUE_W-1:0] pair;
   logic [2*VALUE_W-1:0] aligned;

   always_comb begin
      pair = {hi_word, lo_word};
      merged_lo = (lo_word & ~wmask[VALUE_W-1:0]) | wdata[VALUE_W-1:0];
      merged_hi = (hi_word & ~wmask[2*VALUE_W-1:VALUE_W]) | wdata[2*VALUE_W-1:VALUE_W];
      aligned = pair >> ctl.off;
      if (ctl.op == OP_READ && !ctl.oor) begin
         read_value = aligned[VALUE_W-1:0] & low_mask(ctl.width);
      end else begin
         read_value = '0;
      end
   end

endmodule

/* hw/rtl/bit_field_pack_store.sv */
// A word is accepted in ST_IDLE, which reads both banks; its result is registered in ST_WRITE.
// ST_WRITE does the banks' read-modify-write, stalls on a busy response and takes no new word.
// A field spans at most two 64-bit store words, one in the even bank and one in the odd bank.
// Reset is synchronous; it clears the fill length and the written-extent mark at once, so the
// store reads as all zeros right after reset without any clearing pass over the memory.
module bit_field_pack_store #(
   parameter int unsigned CAPACITY_BITS = bfps_pkg::DEF_CAPACITY_BITS
) (
   input logic clock,
   input logic reset,
   bfps_req_if.sink   req_ch,
   bfps_rsp_if.source rsp_ch
);
   import bfps_pkg::*;

   localparam int unsigned LEN_W = $clog2(CAPACITY_BITS + 1);
   localparam int unsigned START_W = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam int unsigned SUM_W = START_W + 1;
   localparam int unsigned KW = START_W - OFF_W + 1;
   localparam int unsigned WORDS = (CAPACITY_BITS + VALUE_W - 1) / VALUE_W;
   localparam int unsigned BANK_DEPTH = WORDS / 2 + 1;
   localparam int unsigned ADDR_W = $clog2(BANK_DEPTH);

   typedef enum logic {ST_IDLE, ST_WRITE} state_type;

   state_type state_ff;

   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [KW-1:0]    hwm_ff, hwm_in;

   logic               req_fire, req_append, req_read, req_oor;
   logic [START_W-1:0] start;
   logic [SUM_W-1:0]   sum, end_round;
   logic [KW-1:0]      word_lo, word_hi, end_words;
   logic [VALUE_W-1:0] field_mask;
   logic [2*VALUE_W-1:0] wdata_c, wmask_c;

   ctl_type              ctl_ff;
   logic [2*VALUE_W-1:0] wdata_ff, wmask_ff;
   logic                 par_ff, vld_lo_ff, vld_hi_ff;
   logic [ADDR_W-1:0]    even_addr, odd_addr, even_addr_ff, odd_addr_ff;

   logic [VALUE_W-1:0] even_mem [BANK_DEPTH];
   logic [VALUE_W-1:0] odd_mem [BANK_DEPTH];
   logic [VALUE_W-1:0] even_rd_ff, odd_rd_ff;

   logic               wr_go, write_lo, write_hi, even_we, odd_we;
   logic [VALUE_W-1:0] lo_word, hi_word, merged_lo, merged_hi, rd_value;
   logic [VALUE_W-1:0] even_wdata, odd_wdata;

   logic               rsp_valid_ff, oor_ff;
   logic [VALUE_W-1:0] read_value_ff;
   logic [COUNT_W-1:0] count_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      req_append = (req_ch.func == OP_APPEND);
      req_read = (req_ch.func == OP_READ);
      start = req_append ? START_W'(fill_ff) : START_W'(req_ch.bit_position);
      sum = SUM_W'(start) + SUM_W'(req_ch.field_width);
      req_oor = (req_append || req_read) &&
                ((req_ch.field_width > WIDTH_W'(MAX_FIELD)) ||
                 (sum > SUM_W'(CAPACITY_BITS)));
      word_lo = KW'(start[START_W-1:OFF_W]);
      word_hi = word_lo + KW'(1);
      // Word k sits in bank k[0] at row k/2; word k+1 in the other bank.
      even_addr = word_hi[ADDR_W:1];
      odd_addr = word_lo[ADDR_W:1];
      field_mask = low_mask(req_ch.field_width);
      wdata_c = {{VALUE_W{1'b0}}, req_ch.write_value & field_mask} << start[OFF_W-1:0];
      wmask_c = {{VALUE_W{1'b0}}, field_mask} << start[OFF_W-1:0];
      end_round = sum + SUM_W'(VALUE_W - 1);
      end_words = KW'(end_round >> OFF_W);

      fill_in = fill_ff;
      hwm_in = hwm_ff;
      if (req_append && !req_oor) begin
         fill_in = LEN_W'(sum);
         if (end_words > hwm_ff) begin
            hwm_in = end_words;
         end
      end else if (req_ch.func == OP_CLEAR) begin
         fill_in = '0;
      end
   end

   // Words at or above the written-extent mark have never been stored and read as zero.
   always_comb begin
      lo_word = vld_lo_ff ? (par_ff ? odd_rd_ff : even_rd_ff) : '0;
      hi_word = vld_hi_ff ? (par_ff ? even_rd_ff : odd_rd_ff) : '0;
   end

   bfps_merge u_merge (
      .ctl        (ctl_ff),
      .lo_word    (lo_word),
      .hi_word    (hi_word),
      .wdata      (wdata_ff),
      .wmask      (wmask_ff),
      .merged_lo  (merged_lo),
      .merged_hi  (merged_hi),
      .read_value (rd_value)
   );

   always_comb begin
      wr_go = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ch.ready);
      write_lo = wr_go && (ctl_ff.op == OP_APPEND) && !ctl_ff.oor &&
                 (|wmask_ff[VALUE_W-1:0]);
      write_hi = wr_go && (ctl_ff.op == OP_APPEND) && !ctl_ff.oor &&
                 (|wmask_ff[2*VALUE_W-1:VALUE_W]);
      even_we = par_ff ? write_hi : write_lo;
      odd_we = par_ff ? write_lo : write_hi;
      even_wdata = par_ff ? merged_hi : merged_lo;
      odd_wdata = par_ff ? merged_lo : merged_hi;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         even_rd_ff <= even_mem[even_addr];
      end
      if (even_we) begin
         even_mem[even_addr_ff] <= even_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         odd_rd_ff <= odd_mem[odd_addr];
      end
      if (odd_we) begin
         odd_mem[odd_addr_ff] <= odd_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff <= '0;
         hwm_ff <= '0;
      end else begin
         if (wr_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_WRITE;
                  fill_ff <= fill_in;
                  hwm_ff <= hwm_in;
                  ctl_ff.op <= req_ch.func;
                  ctl_ff.oor <= req_oor;
                  ctl_ff.off <= start[OFF_W-1:0];
                  ctl_ff.width <= req_ch.field_width;
                  wdata_ff <= wdata_c;
                  wmask_ff <= wmask_c;
                  par_ff <= word_lo[0];
                  vld_lo_ff <= (word_lo < hwm_ff);
                  vld_hi_ff <= (word_hi < hwm_ff);
                  even_addr_ff <= even_addr;
                  odd_addr_ff <= odd_addr;
               end
            end
            ST_WRITE: begin
               if (wr_go) begin
                  state_ff <= ST_IDLE;
                  read_value_ff <= rd_value;
                  count_ff <= COUNT_W'(fill_ff);
                  oor_ff <= ctl_ff.oor;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.read_value = read_value_ff;
   assign rsp_ch.bit_count = count_ff;
   assign rsp_ch.out_of_range = oor_ff;

   a_fill_within_capacity: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(CAPACITY_BITS))
      else $error("fill length beyond capacity");

   a_extent_covers_fill: assert property (@(posedge clock) disable iff (reset)
      ({hwm_ff, {OFF_W{1'b0}}} >= (KW + OFF_W)'(fill_ff)))
      else $error("written extent below fill length");

   a_refused_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && oor_ff) |-> (read_value_ff == '0))
      else $error("refused operation returned data");

   a_write_only_on_append: assert property (@(posedge clock) disable iff (reset)
      (even_we || odd_we) |-> ((ctl_ff.op == OP_APPEND) && !ctl_ff.oor && wr_go))
      else $error("store written outside an accepted append");

   a_accept_then_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !rsp_valid_ff) |=> ##1 rsp_valid_ff)
      else $error("result not delivered after accept");

endmodule

/* dv/bit_field_pack_store_tb.sv */
module bit_field_pack_store_tb;
   import bfps_pkg::*;

   localparam int unsigned CAP = DEF_CAPACITY_BITS;
   localparam int unsigned STORE_BYTES = (CAP + 7) / 8;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] write_value;
      logic [WIDTH_W-1:0] field_width;
      logic [POS_W-1:0]   bit_position;
   } word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] bit_count;
      logic               out_of_range;
   } result_type;

   logic clock;
   logic reset;
   bit   steady;
   int   errors;
   int unsigned quiet_cycles;

   // Shadow copy of the bit store and its fill length.
   bit [7:0]    shadow_bytes [STORE_BYTES];
   int unsigned shadow_fill;
   result_type  awaited_results [$];

   bfps_req_if req_ch ();
   bfps_rsp_if rsp_ch ();

   bit_field_pack_store i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   function automatic word_type make_word(input logic [FUNC_W-1:0] func,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [WIDTH_W-1:0] width,
                                          input logic [POS_W-1:0] pos);
      word_type w;
      w.func = func;
      w.write_value = value;
      w.field_width = width;
      w.bit_position = pos;
      return w;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      return {$urandom, $urandom};
   endfunction

   // Applies one word to the shadow store and returns the result it must produce.
   function automatic result_type bit_store_op(input word_type w);
      result_type  r;
      int unsigned idx;
      int unsigned i;
      r = '0;
      case (w.func)
         OP_APPEND: begin
            if (w.field_width > MAX_FIELD || shadow_fill + w.field_width > CAP) begin
               r.out_of_range = 1'b1;
            end else begin
               for (i = 0; i < w.field_width; i++) begin
                  idx = shadow_fill + i;
                  shadow_bytes[idx >> 3][idx & 7] = w.write_value[i];
               end
               shadow_fill += w.field_width;
            end
         end
         OP_READ: begin
            if (w.field_width > MAX_FIELD || w.bit_position + w.field_width > CAP) begin
               r.out_of_range = 1'b1;
            end else begin
               for (i = 0; i < w.field_width; i++) begin
                  idx = w.bit_position + i;
                  r.read_value[i] = shadow_bytes[idx >> 3][idx & 7];
               end
            end
         end
         OP_CLEAR: begin
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      r.bit_count = COUNT_W'(shadow_fill);
      return r;
   endfunction

   // Results are checked before the word accepted at the same edge is predicted.
   always @(posedge clock) begin : track_words
      result_type exp_r;
      word_type   w;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual %h %h %b", $time,
                        rsp_ch.read_value, rsp_ch.bit_count, rsp_ch.out_of_range);
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_ch.read_value !== exp_r.read_value) begin
                  errors++;
                  $display("%0t: read_value mismatch: expected %h, actual %h", $time,
                           exp_r.read_value, rsp_ch.read_value);
               end
               if (rsp_ch.bit_count !== exp_r.bit_count) begin
                  errors++;
                  $display("%0t: bit_count mismatch: expected %0d, actual %0d", $time,
                           exp_r.bit_count, rsp_ch.bit_count);
               end
               if (rsp_ch.out_of_range !== exp_r.out_of_range) begin
                  errors++;
                  $display("%0t: out_of_range mismatch: expected %b, actual %b", $time,
                           exp_r.out_of_range, rsp_ch.out_of_range);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            w = make_word(req_ch.func, req_ch.write_value, req_ch.field_width,
                          req_ch.bit_position);
            awaited_results.push_back(bit_store_op(w));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
                  quiet_cycles, awaited_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 15);
   end

   task automatic send_word(input word_type w);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 15) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= w.func;
      req_ch.write_value <= w.write_value;
      req_ch.field_width <= w.field_width;
      req_ch.bit_position <= w.bit_position;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops sending and waits until every outstanding result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(make_word(OP_READ, '0, 7'd64, 15'd0));
      send_word(make_word(OP_APPEND, '1, 7'd0, 15'd0));
      send_word(make_word(OP_APPEND, 64'd1, 7'd1, 15'd0));
      send_word(make_word(OP_APPEND, '1, 7'd64, 15'd0));
      send_word(make_word(OP_APPEND, 64'hA5C3_0F96_5A3C_F069, 7'd64, '1));
      send_word(make_word(OP_APPEND, rand_value(), 7'd13, 15'd0));
      send_word(make_word(OP_READ, '1, 7'd64, 15'd0));
      send_word(make_word(OP_READ, '0, 7'd64, 15'd1));
      send_word(make_word(OP_READ, '0, 7'd13, 15'd60));
      // Past the fill length but never written: reset zeros.
      send_word(make_word(OP_READ, '0, 7'd8, 15'd200));
      send_word(make_word(OP_READ, '0, 7'd0, 15'd5));
      send_word(make_word(OP_READ, '0, 7'd65, 15'd0));
      send_word(make_word(OP_APPEND, '1, 7'd65, 15'd0));
      send_word(make_word(OP_APPEND, '1, '1, 15'd0));
      send_word(make_word(OP_READ, '0, '1, 15'd0));
      send_word(make_word(OP_READ, '0, 7'd1, '1));
      send_word(make_word(OP_READ, '0, 7'd2, '1));
      send_word(make_word(OP_READ, '0, 7'd64, 15'(CAP - 64)));
      send_word(make_word(FUNC_UNUSED, '1, '1, '1));
      send_word(make_word(OP_CLEAR, '1, 7'd5, 15'd9));
      // After a clear the old contents stay readable.
      send_word(make_word(OP_READ, '0, 7'd64, 15'd0));
      send_word(make_word(OP_APPEND, '0, 7'd3, 15'd0));
      send_word(make_word(OP_READ, '0, 7'd64, 15'd0));
      send_word(make_word(OP_READ, '0, 7'd64, '1));
   endtask

   task automatic test_fill_to_capacity();
      int k;
      send_word(make_word(OP_CLEAR, '0, '0, '0));
      for (k = 0; k < CAP / 64 - 1; k++) begin
         send_word(make_word(OP_APPEND, rand_value(), 7'd64, 15'($urandom)));
      end
      send_word(make_word(OP_APPEND, rand_value(), 7'd57, '0));
      send_word(make_word(OP_APPEND, rand_value(), 7'd8, '0));
      send_word(make_word(OP_APPEND, rand_value(), 7'd7, '0));
      send_word(make_word(OP_APPEND, rand_value(), 7'd1, '0));
      send_word(make_word(OP_APPEND, rand_value(), 7'd0, '0));
      send_word(make_word(OP_READ, '0, 7'd64, 15'(CAP - 64)));
      send_word(make_word(OP_READ, '0, 7'd64, 15'(CAP - 65)));
      send_word(make_word(OP_READ, '0, 7'd1, '1));
      send_word(make_word(OP_READ, '0, 7'd2, '1));
      send_word(make_word(OP_CLEAR, '0, '0, '0));
   endtask

   // Mostly appends and reads up to 64 bits past the fill length, with some noise.
   task automatic test_random(input int count);
      int          k;
      int unsigned sel;
      int unsigned hint;
      word_type    w;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(99);
         hint = (shadow_fill + 64 < CAP) ? shadow_fill + 64 : CAP - 1;
         w = make_word(OP_READ, rand_value(), 7'($urandom_range(0, MAX_FIELD)),
                       15'($urandom_range(0, hint)));
         if (sel < 45) begin
            w.func = OP_APPEND;
         end else if (sel < 80) begin
            w.func = OP_READ;
         end else if (sel < 84) begin
            w.func = OP_CLEAR;
         end else if (sel < 90) begin
            w.bit_position = ($urandom_range(1) != 0) ? 15'($urandom)
                             : 15'(CAP - 1 - $urandom_range(0, 70));
            if ($urandom_range(1) != 0) w.field_width = 7'($urandom);
         end else if (sel < 95) begin
            w.func = OP_APPEND;
            w.field_width = 7'($urandom);
         end else begin
            w.func = FUNC_UNUSED;
            w.field_width = 7'($urandom);
            w.bit_position = 15'($urandom);
         end
         send_word(w);
         if (k == count / 2) wait_drained();
      end
   endtask

   task automatic test_back_to_back(input int count);
      steady = 1'b1;
      test_random(count);
      steady = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      errors = 0;
      quiet_cycles = 0;
      shadow_fill = 0;
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.write_value = '0;
      req_ch.field_width = '0;
      req_ch.bit_position = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_to_capacity();
      test_random(300);
      test_back_to_back(100);
      test_random(60);
      wait_drained();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
